[rtl/core/rfp_pkg.sv]
`timescale 1ns / 1ps

package rfp_pkg;

  localparam int unsigned LEN_BITS_DEF = 32;
  localparam logic [31:0] MAX_LENGTH_RST = 32'h2000_0000;

  // Magnitude limits for signed 64-bit decimal values, widened for the x10 sum.
  localparam logic [67:0] NUM_POS_LIM = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] NUM_NEG_LIM = 68'h0_8000_0000_0000_0000;

  localparam logic [7:0] CH_DOLLAR     = "$";
  localparam logic [7:0] CH_STAR       = "*";
  localparam logic [7:0] CH_COLON      = ":";
  localparam logic [7:0] CH_PLUS       = "+";
  localparam logic [7:0] CH_MINUS      = "-";
  localparam logic [7:0] CH_HASH       = "#";
  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_BANG       = "!";
  localparam logic [7:0] CH_EQUALS     = "=";
  localparam logic [7:0] CH_LPAREN     = "(";
  localparam logic [7:0] CH_COMMA      = ",";
  localparam logic [7:0] CH_TRUE       = "t";
  localparam logic [7:0] CH_FALSE      = "f";
  localparam logic [7:0] CH_ZERO       = "0";
  localparam logic [7:0] CH_NINE       = "9";
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;

  typedef enum logic [3:0] {
    KIND_BULK     = 4'd0,
    KIND_SIMPLE   = 4'd1,
    KIND_ERROR    = 4'd2,
    KIND_INTEGER  = 4'd3,
    KIND_BOOLEAN  = 4'd4,
    KIND_NULL     = 4'd5,
    KIND_ARRAY    = 4'd6,
    KIND_BULKERR  = 4'd7,
    KIND_VERBATIM = 4'd8,
    KIND_BIGNUM   = 4'd9,
    KIND_DOUBLE   = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_BAD_DIGIT = 3'd2,
    ST_NO_CRLF   = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_NUM,
    PH_NUM_LF,
    PH_PAYLOAD,
    PH_TEXT,
    PH_BOOL,
    PH_TAIL_CR,
    PH_TAIL_LF,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         data_byte;
    logic               is_payload;
    logic               frame_end;
    logic signed [63:0] number;
    logic [2:0]         status;
  } rfp_result_t;

endpackage

[rtl/core/rfp_ifs.sv]
`timescale 1ns / 1ps

interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rfp_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [7:0]         data_byte;
  logic               is_payload;
  logic               frame_end;
  logic signed [63:0] number;
  logic [2:0]         status;

  modport source (output valid, output kind, output data_byte, output is_payload,
                  output frame_end, output number, output status, input ready);
  modport sink (input valid, input kind, input data_byte, input is_payload,
                input frame_end, input number, input status, output ready);
endinterface

interface rfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_length;

  modport source (output valid, output max_length, input ready);
  modport sink (input valid, input max_length, output ready);
endinterface

[rtl/core/rfp_cfg_reg.sv]
`timescale 1ns / 1ps

module rfp_cfg_reg import rfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rfp_cfg_if.sink     cfg_ch,
  output logic [31:0] max_length
);

  logic [31:0] max_length_r;

  assign cfg_ch.ready = 1'b1;
  assign max_length   = max_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RST;
    end else if (cfg_ch.valid) begin
      max_length_r <= cfg_ch.max_length;
    end
  end

endmodule

[rtl/core/rfp_in_reg.sv]
`timescale 1ns / 1ps

module rfp_in_reg import rfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rfp_in_if.sink     in_ch,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] byte_r;

  // The register refills in the same cycle that its item moves on to the parser.
  assign in_ch.ready = !valid_r || take;
  assign byte_valid  = valid_r;
  assign byte_data   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.in_byte;
    end
  end

endmodule

[rtl/core/rfp_parse_core.sv]
`timescale 1ns / 1ps

module rfp_parse_core import rfp_pkg::*; #(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  logic [7:0]  byte_data,
  input  logic [31:0] max_length,
  output logic        res_valid,
  output rfp_result_t res
);

  phase_t                phase_r, phase_nxt;
  logic [3:0]            kind_r, kind_nxt;
  logic [63:0]           acc_r, acc_nxt;
  logic                  neg_r, neg_nxt;
  logic                  digit_seen_r, digit_seen_nxt;
  logic [LEN_BITS-1:0]   left_r, left_nxt;

  logic                  is_digit;
  logic [3:0]            digit_val;
  logic [67:0]           acc_ext;
  logic [67:0]           acc_x10;
  logic [67:0]           num_lim;
  logic [LEN_BITS-1:0]   left_dec;
  logic                  len_too_big;

  assign is_digit    = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
  assign digit_val   = 4'(byte_data - CH_ZERO);
  assign acc_ext     = {4'b0, acc_r};
  assign acc_x10     = (acc_ext << 3) + (acc_ext << 1) + 68'(digit_val);
  assign num_lim     = neg_r ? NUM_NEG_LIM : NUM_POS_LIM;
  assign left_dec    = left_r - {{(LEN_BITS-1){1'b0}}, 1'b1};
  assign len_too_big = (|(acc_r >> LEN_BITS)) || (acc_r > {32'd0, max_length});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      kind_r       <= KIND_BULK;
      acc_r        <= '0;
      neg_r        <= 1'b0;
      digit_seen_r <= 1'b0;
      left_r       <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      kind_r       <= kind_nxt;
      acc_r        <= acc_nxt;
      neg_r        <= neg_nxt;
      digit_seen_r <= digit_seen_nxt;
      left_r       <= left_nxt;
    end
  end

  always_comb begin
    logic    start_en;
    logic    fail_en;
    status_t fail_st;

    start_en       = 1'b0;
    fail_en        = 1'b0;
    fail_st        = ST_OK;
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    digit_seen_nxt = digit_seen_r;
    left_nxt       = left_r;
    res_valid      = 1'b0;
    res            = '0;
    res.kind       = kind_r;
    res.status     = ST_OK;

    unique case (phase_r)
      PH_IDLE: begin
        start_en = 1'b1;
        case (byte_data)
          CH_DOLLAR:     begin kind_nxt = KIND_BULK;     phase_nxt = PH_NUM;     end
          CH_PLUS:       begin kind_nxt = KIND_SIMPLE;   phase_nxt = PH_TEXT;    end
          CH_MINUS:      begin kind_nxt = KIND_ERROR;    phase_nxt = PH_TEXT;    end
          CH_COLON:      begin kind_nxt = KIND_INTEGER;  phase_nxt = PH_NUM;     end
          CH_HASH:       begin kind_nxt = KIND_BOOLEAN;  phase_nxt = PH_BOOL;    end
          CH_UNDERSCORE: begin kind_nxt = KIND_NULL;     phase_nxt = PH_TAIL_CR; end
          CH_STAR:       begin kind_nxt = KIND_ARRAY;    phase_nxt = PH_NUM;     end
          CH_BANG:       begin kind_nxt = KIND_BULKERR;  phase_nxt = PH_NUM;     end
          CH_EQUALS:     begin kind_nxt = KIND_VERBATIM; phase_nxt = PH_NUM;     end
          CH_LPAREN:     begin kind_nxt = KIND_BIGNUM;   phase_nxt = PH_TEXT;    end
          CH_COMMA:      begin kind_nxt = KIND_DOUBLE;   phase_nxt = PH_TEXT;    end
          default: begin
            start_en = 1'b0;
            kind_nxt = KIND_BULK;
            fail_en  = 1'b1;
            fail_st  = ST_BAD_TYPE;
          end
        endcase
      end

      PH_NUM: begin
        priority if (is_digit) begin
          // Overflow when ten times the magnitude plus the digit passes the signed limit.
          if (acc_x10 > num_lim) begin
            fail_en = 1'b1;
            fail_st = ST_RANGE;
          end else begin
            acc_nxt        = acc_x10[63:0];
            digit_seen_nxt = 1'b1;
          end
        end else if (byte_data == CH_MINUS && !digit_seen_r && !neg_r) begin
          neg_nxt = 1'b1;
        end else if (byte_data == CH_LF) begin
          fail_en = 1'b1;
          fail_st = ST_NO_CRLF;
        end else if (byte_data == CH_CR && digit_seen_r) begin
          phase_nxt = PH_NUM_LF;
        end else begin
          fail_en = 1'b1;
          fail_st = ST_BAD_DIGIT;
        end
      end

      PH_NUM_LF: begin
        phase_nxt = PH_IDLE;
        priority if (byte_data != CH_LF) begin
          fail_en = 1'b1;
          fail_st = ST_NO_CRLF;
        end else if (kind_r == KIND_INTEGER) begin
          res_valid     = 1'b1;
          res.frame_end = 1'b1;
          res.number    = $signed(neg_r ? (64'd0 - acc_r) : acc_r);
        end else if (neg_r && acc_r == 64'd1 &&
                     (kind_r == KIND_BULK || kind_r == KIND_ARRAY)) begin
          // A length or count of minus one is the null reply.
          kind_nxt      = KIND_NULL;
          res_valid     = 1'b1;
          res.kind      = KIND_NULL;
          res.frame_end = 1'b1;
        end else if (neg_r && acc_r != 64'd0) begin
          fail_en = 1'b1;
          fail_st = ST_RANGE;
        end else if (kind_r == KIND_ARRAY) begin
          res_valid     = 1'b1;
          res.frame_end = 1'b1;
          res.number    = $signed(acc_r);
        end else if (len_too_big) begin
          fail_en = 1'b1;
          fail_st = ST_RANGE;
        end else begin
          neg_nxt   = 1'b0;
          left_nxt  = acc_r[LEN_BITS-1:0];
          phase_nxt = (acc_r == 64'd0) ? PH_TAIL_CR : PH_PAYLOAD;
        end
      end

      PH_PAYLOAD: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_TAIL_CR;
        end
        res_valid      = 1'b1;
        res.data_byte  = byte_data;
        res.is_payload = 1'b1;
      end

      PH_TEXT: begin
        priority if (byte_data == CH_LF) begin
          fail_en = 1'b1;
          fail_st = ST_NO_CRLF;
        end else if (byte_data == CH_CR) begin
          phase_nxt = PH_TAIL_LF;
        end else begin
          acc_nxt        = acc_r + 64'd1;
          res_valid      = 1'b1;
          res.data_byte  = byte_data;
          res.is_payload = 1'b1;
        end
      end

      PH_BOOL: begin
        if (byte_data == CH_TRUE || byte_data == CH_FALSE) begin
          acc_nxt   = {63'd0, byte_data == CH_TRUE};
          phase_nxt = PH_TAIL_CR;
        end else begin
          fail_en = 1'b1;
          fail_st = ST_BAD_DIGIT;
        end
      end

      PH_TAIL_CR: begin
        if (byte_data != CH_CR) begin
          fail_en = 1'b1;
          fail_st = ST_NO_CRLF;
        end else begin
          phase_nxt = PH_TAIL_LF;
        end
      end

      PH_TAIL_LF: begin
        if (byte_data != CH_LF) begin
          fail_en = 1'b1;
          fail_st = ST_NO_CRLF;
        end else begin
          phase_nxt     = PH_IDLE;
          res_valid     = 1'b1;
          res.frame_end = 1'b1;
          res.number    = $signed(acc_r);
        end
      end

      PH_SKIP: begin
        if (byte_data == CH_LF) begin
          phase_nxt = PH_IDLE;
        end
      end

      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (start_en) begin
      acc_nxt        = '0;
      neg_nxt        = 1'b0;
      digit_seen_nxt = 1'b0;
      left_nxt       = '0;
    end

    // An aborted frame reports its own kind (bulk for a bad type byte), then drops bytes up to the next LF.
    if (fail_en) begin
      res_valid      = 1'b1;
      res            = '0;
      res.kind       = kind_nxt;
      res.frame_end  = 1'b1;
      res.status     = fail_st;
      phase_nxt      = (byte_data == CH_LF) ? PH_IDLE : PH_SKIP;
    end
  end

endmodule

[rtl/core/rfp_out_reg.sv]
`timescale 1ns / 1ps

module rfp_out_reg import rfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  rfp_result_t res,
  output logic        free,
  rfp_out_if.source   out_ch
);

  logic        valid_r;
  rfp_result_t res_r;

  assign free              = !valid_r || out_ch.ready;
  assign out_ch.valid      = valid_r;
  assign out_ch.kind       = res_r.kind;
  assign out_ch.data_byte  = res_r.data_byte;
  assign out_ch.is_payload = res_r.is_payload;
  assign out_ch.frame_end  = res_r.frame_end;
  assign out_ch.number     = res_r.number;
  assign out_ch.status     = res_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

[rtl/core/resp_frame_parser.sv]
`timescale 1ns / 1ps

// Streaming parser for key-value-store replies in the RESP3 wire format.
// in_ch carries one byte of the reply stream per item; out_ch gives at most
// one result item per byte: a payload byte, or a frame end with the kind,
// the number (integer, boolean, length or array count) and a status.
// Array elements come out as frames of their own after the array header.
// cfg_ch writes max_length, the largest accepted bulk payload length; it is
// always ready and should only be written while the parser is idle.
// Each accepted byte is held in the input register and then parsed into the
// result register, from which out_ch offers any result that the byte gives.
// Throughput: one byte per cycle while out_ch does not stall, set by the single
// parse step between the input register and the result register.
// Reset clears both registers, returns the parser to waiting for a type byte
// and sets max_length to 2^29.
// When out_ch stalls with a result waiting, one further byte is taken into
// the input register, then in_ch.ready stays low until the result is taken.
// On any error a frame end with nonzero status is given and bytes are
// dropped up to and including the next LF.

module resp_frame_parser import rfp_pkg::*; #(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rfp_in_if.sink    in_ch,
  rfp_out_if.source out_ch,
  rfp_cfg_if.sink   cfg_ch
);

  logic        byte_valid;
  logic [7:0]  byte_data;
  logic [31:0] max_length;
  logic        out_free;
  logic        advance;
  logic        res_valid;
  rfp_result_t res;

  assign advance = byte_valid && out_free;

  rfp_cfg_reg u_cfg_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .max_length (max_length)
  );

  rfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  rfp_parse_core #(
    .LEN_BITS (LEN_BITS)
  ) u_parse_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .byte_data  (byte_data),
    .max_length (max_length),
    .res_valid  (res_valid),
    .res        (res)
  );

  rfp_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance && res_valid),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_payload_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_payload |-> !out_ch.frame_end && out_ch.status == ST_OK)
    else $error("payload item flagged as frame end or error");

  a_error_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.frame_end && out_ch.number == 64'sd0)
    else $error("error item without frame end or with a number");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    byte_valid && !advance |=> byte_valid && $stable(byte_data))
    else $error("byte in input register lost while stalled");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> byte_valid)
    else $error("accepted byte did not reach input register");
`endif

endmodule

[test/tb_resp_frame_parser.sv]
`timescale 1ns / 1ps

module tb_resp_frame_parser;
  import rfp_pkg::*;

  localparam int unsigned LB = LEN_BITS_DEF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data = 8'd0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data = 32'd0;

  rfp_in_if  in_if ();
  rfp_out_if out_if ();
  rfp_cfg_if cfg_if ();

  assign in_if.valid       = in_valid;
  assign in_if.in_byte     = in_data;
  assign out_if.ready      = out_ready;
  assign cfg_if.valid      = cfg_valid;
  assign cfg_if.max_length = cfg_data;

  resp_frame_parser #(.LEN_BITS(LB)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state as predicted from the bytes taken so far.
  phase_t          pr_phase = PH_IDLE;
  logic [3:0]      pr_kind = KIND_BULK;
  logic [63:0]     pr_acc = 64'd0;
  logic            pr_neg = 1'b0;
  logic [4:0]      pr_digits = 5'd0;
  logic [LB-1:0]   pr_left = '0;
  logic [31:0]     max_len = MAX_LENGTH_RST;

  rfp_result_t results_due[$];
  logic [7:0]  bytes_pending[$];
  logic [7:0]  frame_bytes[$];

  int unsigned bytes_presented = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned results_paced = 0;
  int unsigned mismatch_count = 0;
  int unsigned phase_bytes = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  function automatic string fmt_result(rfp_result_t r);
    return $sformatf("kind %0d byte %02h pay %0b end %0b number %0d status %0d",
                     r.kind, r.data_byte, r.is_payload, r.frame_end, r.number, r.status);
  endfunction

  task automatic emit(input logic [3:0] k, input logic [7:0] d, input logic pay,
                      input logic fe, input logic [63:0] num, input status_t st);
    rfp_result_t r;
    r.kind       = k;
    r.data_byte  = d;
    r.is_payload = pay;
    r.frame_end  = fe;
    r.number     = num;
    r.status     = st;
    results_due = {results_due, r};
  endtask

  // An error closes the frame; an LF as the offending byte resynchronises at once.
  task automatic abort(input status_t st, input logic [7:0] b);
    pr_phase = (b == CH_LF) ? PH_IDLE : PH_SKIP;
    emit(pr_kind, 8'd0, 1'b0, 1'b1, 64'd0, st);
  endtask

  task automatic open_frame(input logic [3:0] k, input phase_t nxt);
    pr_kind   = k;
    pr_phase  = nxt;
    pr_acc    = 64'd0;
    pr_neg    = 1'b0;
    pr_digits = 5'd0;
    pr_left   = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [63:0] dig, cap, mag, val;
    dig = 64'(b) - 64'(CH_ZERO);
    case (pr_phase)
      PH_IDLE: begin
        case (b)
          CH_DOLLAR:     open_frame(KIND_BULK, PH_NUM);
          CH_PLUS:       open_frame(KIND_SIMPLE, PH_TEXT);
          CH_MINUS:      open_frame(KIND_ERROR, PH_TEXT);
          CH_COLON:      open_frame(KIND_INTEGER, PH_NUM);
          CH_HASH:       open_frame(KIND_BOOLEAN, PH_BOOL);
          CH_UNDERSCORE: open_frame(KIND_NULL, PH_TAIL_CR);
          CH_STAR:       open_frame(KIND_ARRAY, PH_NUM);
          CH_BANG:       open_frame(KIND_BULKERR, PH_NUM);
          CH_EQUALS:     open_frame(KIND_VERBATIM, PH_NUM);
          CH_LPAREN:     open_frame(KIND_BIGNUM, PH_TEXT);
          CH_COMMA:      open_frame(KIND_DOUBLE, PH_TEXT);
          default: begin
            pr_kind = KIND_BULK;
            abort(ST_BAD_TYPE, b);
          end
        endcase
      end
      PH_NUM: begin
        // A negative value may reach one further than a positive one.
        cap = pr_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (b >= CH_ZERO && b <= CH_NINE) begin
          if (pr_acc > (cap - dig) / 64'd10) begin
            abort(ST_RANGE, b);
          end else begin
            pr_acc = pr_acc * 64'd10 + dig;
            if (pr_digits != 5'd31) pr_digits = pr_digits + 5'd1;
          end
        end else if (b == CH_MINUS && pr_digits == 5'd0 && !pr_neg) begin
          pr_neg = 1'b1;
        end else if (b == CH_LF) begin
          abort(ST_NO_CRLF, b);
        end else if (b == CH_CR && pr_digits != 5'd0) begin
          pr_phase = PH_NUM_LF;
        end else begin
          abort(ST_BAD_DIGIT, b);
        end
      end
      PH_NUM_LF: begin
        if (b != CH_LF) begin
          abort(ST_NO_CRLF, b);
        end else begin
          mag = pr_acc;
          val = pr_neg ? 64'd0 - mag : mag;
          pr_phase = PH_IDLE;
          if (pr_kind == KIND_INTEGER) begin
            emit(KIND_INTEGER, 8'd0, 1'b0, 1'b1, val, ST_OK);
          end else if (pr_neg && mag == 64'd1 &&
                       (pr_kind == KIND_BULK || pr_kind == KIND_ARRAY)) begin
            pr_kind = KIND_NULL;
            emit(KIND_NULL, 8'd0, 1'b0, 1'b1, 64'd0, ST_OK);
          end else if (pr_neg && mag != 64'd0) begin
            abort(ST_RANGE, CH_LF);
          end else if (pr_kind == KIND_ARRAY) begin
            emit(KIND_ARRAY, 8'd0, 1'b0, 1'b1, mag, ST_OK);
          end else if (mag > {32'd0, max_len} || (mag >> LB) != 64'd0) begin
            abort(ST_RANGE, CH_LF);
          end else begin
            pr_neg   = 1'b0;
            pr_left  = mag[LB-1:0];
            pr_phase = (mag == 64'd0) ? PH_TAIL_CR : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pr_left = pr_left - LB'(1);
        if (pr_left == '0) pr_phase = PH_TAIL_CR;
        emit(pr_kind, b, 1'b1, 1'b0, 64'd0, ST_OK);
      end
      PH_TEXT: begin
        if (b == CH_LF) begin
          abort(ST_NO_CRLF, b);
        end else if (b == CH_CR) begin
          pr_phase = PH_TAIL_LF;
        end else begin
          pr_acc = pr_acc + 64'd1;
          emit(pr_kind, b, 1'b1, 1'b0, 64'd0, ST_OK);
        end
      end
      PH_BOOL: begin
        if (b == CH_TRUE || b == CH_FALSE) begin
          pr_acc   = (b == CH_TRUE) ? 64'd1 : 64'd0;
          pr_phase = PH_TAIL_CR;
        end else begin
          abort(ST_BAD_DIGIT, b);
        end
      end
      PH_TAIL_CR: begin
        if (b != CH_CR) abort(ST_NO_CRLF, b);
        else pr_phase = PH_TAIL_LF;
      end
      PH_TAIL_LF: begin
        if (b != CH_LF) begin
          abort(ST_NO_CRLF, b);
        end else begin
          pr_phase = PH_IDLE;
          emit(pr_kind, 8'd0, 1'b0, 1'b1, pr_acc, ST_OK);
        end
      end
      default: begin
        if (b == CH_LF) pr_phase = PH_IDLE;
      end
    endcase
  endtask

  // Byte driver: one item presented at a time, a random pause drawn after each.
  always @(negedge clk) begin
    if (rst_n && bytes_presented == bytes_taken) begin
      if (in_gap != 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (bytes_pending.size() != 0) begin
        in_data  <= bytes_pending.pop_front();
        in_valid <= 1'b1;
        bytes_presented = bytes_presented + 1;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, drawn afresh after each item taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (results_seen != results_paced) begin
        results_paced = results_seen;
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_gap = out_calm ? 0 : $urandom_range(0, 12);
      end
      if (out_gap != 0) begin
        out_gap = out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rfp_result_t got, want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.in_byte);
        bytes_taken = bytes_taken + 1;
      end
      if (out_if.valid && out_if.ready) begin
        results_seen   = results_seen + 1;
        got.kind       = out_if.kind;
        got.data_byte  = out_if.data_byte;
        got.is_payload = out_if.is_payload;
        got.frame_end  = out_if.frame_end;
        got.number     = out_if.number;
        got.status     = out_if.status;
        if (results_due.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) $display("unexpected result: %s", fmt_result(got));
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.is_payload !== want.is_payload || got.frame_end !== want.frame_end ||
              got.number !== want.number || got.status !== want.status) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("result %0d mismatch: expected %s", results_seen, fmt_result(want));
              $display("result %0d mismatch: actual   %s", results_seen, fmt_result(got));
            end
          end
        end
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    frame_bytes = {frame_bytes, b};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic add_line(input string s);
    add_text(s);
    put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  // Moves the frame under construction to the byte stream, sometimes damaged.
  task automatic commit_frame(input bit breakable);
    int unsigned pos;
    if (breakable && frame_bytes.size() != 0 && $urandom_range(0, 7) == 0) begin
      pos = $urandom_range(0, frame_bytes.size() - 1);
      case ($urandom_range(0, 2))
        0: frame_bytes[pos] = 8'($urandom);
        1: while (frame_bytes.size() > pos + 1) void'(frame_bytes.pop_back());
        default: frame_bytes.push_front(8'($urandom));
      endcase
    end
    phase_bytes = phase_bytes + frame_bytes.size();
    while (frame_bytes.size() != 0) bytes_pending = {bytes_pending, frame_bytes.pop_front()};
  endtask

  // Damage is kept away from integers and over-limit length headers, since a single
  // changed byte there could announce a payload of billions of bytes.
  task automatic gen_frame(input logic [31:0] lim);
    logic [63:0] len;
    logic [7:0]  ch;
    string       digits;
    int          count;
    bit          breakable;
    breakable = 1'b1;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin
        case ($urandom_range(0, 2))
          0: ch = CH_DOLLAR;
          1: ch = CH_BANG;
          default: ch = CH_EQUALS;
        endcase
        len = 64'($urandom_range(0, 12));
        case ($urandom_range(0, 11))
          0: len = {32'd0, lim} + 64'd1;
          1: if (lim <= 32'd40) len = {32'd0, lim};
          default: ;
        endcase
        put_byte(ch);
        add_line($sformatf("%0d", len));
        if (len <= {32'd0, lim}) begin
          repeat (int'(len)) put_byte(8'($urandom));
          add_line("");
        end else begin
          breakable = 1'b0;
        end
      end
      4, 5, 6: begin
        case ($urandom_range(0, 3))
          0: ch = CH_PLUS;
          1: ch = CH_MINUS;
          2: ch = CH_LPAREN;
          default: ch = CH_COMMA;
        endcase
        put_byte(ch);
        repeat ($urandom_range(0, 12)) begin
          do ch = 8'($urandom); while (ch == CH_CR || ch == CH_LF);
          put_byte(ch);
        end
        add_line("");
      end
      7, 8: begin
        breakable = 1'b0;
        case ($urandom_range(0, 7))
          0: digits = $sformatf("%0d", $signed({$urandom, $urandom}));
          1: digits = "9223372036854775807";
          2: digits = "-9223372036854775808";
          3: digits = "9223372036854775808";
          4: digits = "-9223372036854775809";
          default: digits = $sformatf("%0d", int'($urandom_range(0, 200)) - 100);
        endcase
        put_byte(CH_COLON);
        add_line(digits);
      end
      9: begin
        put_byte(CH_HASH);
        case ($urandom_range(0, 8))
          0: put_byte(8'($urandom));
          1, 3, 5, 7: put_byte(CH_TRUE);
          default: put_byte(CH_FALSE);
        endcase
        add_line("");
      end
      10: begin
        case ($urandom_range(0, 2))
          0: add_line("_");
          1: add_line("$-1");
          default: add_line("*-1");
        endcase
      end
      default: begin
        if ($urandom_range(0, 5) == 0) begin
          put_byte(8'($urandom));
          breakable = 1'b0;
        end else begin
          count = ($urandom_range(0, 9) == 0) ? -3 : int'($urandom_range(0, 5));
          add_line($sformatf("*%0d", count));
        end
      end
    endcase
    commit_frame(breakable);
  endtask

  task automatic set_max_length(input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    max_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every byte is taken and every expected item has come out, or the wait bound is reached.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while (bytes_pending.size() != 0 || bytes_presented != bytes_taken) @(negedge clk);
    while (results_due.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited = waited + 1;
    end
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [31:0] limit_plan [7];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_max_length(MAX_LENGTH_RST);

    put_byte(CH_DOLLAR);
    add_line("5");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(8'h80);
    add_line("");
    add_line("$0");
    add_line("");
    add_line("$-1");
    add_line("*-1");
    add_line("$-0");
    add_line("");
    add_line("*3");
    add_line("+OK");
    add_line("-ERR wrong");
    add_line(":-0");
    add_line(":9223372036854775807");
    add_line(":-9223372036854775808");
    add_line(":9223372036854775808");
    add_line(":-9223372036854775809");
    add_line(":0000000000000000000000000000000000000042");
    add_line("*9223372036854775807");
    add_line("#t");
    add_line("#f");
    add_line("#T");
    add_line("_");
    add_line("!4");
    add_line("oops");
    add_line("=8");
    add_line("txt:resp");
    add_line("(-12345678901234567890123");
    add_line(",-1.5e10");
    put_byte(CH_PLUS);
    put_byte(8'h00);
    put_byte(8'hFF);
    add_line("");
    // Bad type bytes, including stray CR and LF between frames.
    add_line("?abc");
    put_byte(CH_LF);
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(8'h00);
    put_byte(CH_LF);
    put_byte(8'hFF);
    put_byte(CH_LF);
    // Sign and digit errors.
    add_line(":--5");
    add_line(":+5");
    add_line(":");
    add_line("$-");
    add_line(":1-");
    // Missing CRLF in its various places.
    add_text(":12");
    put_byte(CH_LF);
    add_text("+ab");
    put_byte(CH_LF);
    add_text(":12");
    put_byte(CH_CR);
    add_line("5");
    add_line("$2");
    add_line("abX");
    add_text("_");
    put_byte(CH_LF);
    add_text("#t");
    put_byte(CH_LF);
    // Lengths out of range and digit overflow.
    add_line("$536870913");
    add_line("$-5");
    add_line("*-2");
    add_line("$4294967296");
    add_line("=99999999999");
    add_line("$99999999999999999999");
    commit_frame(1'b0);
    settle();

    limit_plan = '{32'd0, 32'hFFFF_FFFF, 32'd3, 32'($urandom_range(4, 40)), $urandom,
                   32'd12, MAX_LENGTH_RST};
    foreach (limit_plan[p]) begin
      set_max_length(limit_plan[p]);
      phase_bytes = 0;
      while (phase_bytes < 40) gen_frame(limit_plan[p]);
      settle();
    end

    if (results_due.size() != 0) begin
      $display("%0d expected results never arrived", results_due.size());
      mismatch_count = mismatch_count + 1;
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout: parser stopped making progress");
    $display("Regression FAIL");
    $finish;
  end

endmodule
